// File: design/sound_level_meter_with_alarms_top_defines.svh
// ----------------------------------------------------------------------------
// Sound level meter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOUND_LEVEL_METER_WITH_ALARMS_TOP_DEFINES_SVH
`define SOUND_LEVEL_METER_WITH_ALARMS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SLM_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("sound level meter assertion failed");
// Next-cycle implication.
`define SLM_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("sound level meter assertion failed");
`else
`define SLM_ASSERT_IMP(lbl, a, c)
`define SLM_ASSERT_NXT(lbl, a, c)
`endif
`endif

// File: design/slm_pkg.sv
// ----------------------------------------------------------------------------
// Sound level meter package
// Types and fixed constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package slm_pkg;
	localparam int AccW = 56;
	localparam longint SilentAcc = -200 * (64'sd1 <<< 40);
	localparam longint OffsetAcc = 8061603 * (64'sd1 <<< 24) + (64'sd1 <<< 31);
	localparam logic signed [26:0] LogCoef = 27'sd50504453;
	localparam int LevelMin = -65536;
	localparam int LevelMax = 65535;

	localparam logic [1:0] RegSusThr = 2'd0;
	localparam logic [1:0] RegInstThr = 2'd1;
	localparam logic [1:0] RegSusFrames = 2'd2;
	localparam logic [1:0] RegCal = 2'd3;

	typedef struct packed {
		logic take;       // capture input word and square it
		logic acc;        // add the square to the running sum
		logic chk;        // frame end: pick empty, silent or log path
		logic norm;       // one normalizer step
		logic sq;         // one squaring step of the log fraction
		logic swap;       // keep log2(sum), start log2(count)
		logic diff;       // difference of the two logs
		logic mul;        // scale by 10*log10(2)
		logic add;        // add offsets and rounding
		logic fin;        // finish the frame and load the result
	} slm_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic count_zero;
		logic sum_zero;
		logic norm_msb;
		logic k_zero;
		logic sel;
		logic out_free;
	} slm_status_t;

	typedef struct packed {
		logic signed [16:0] sus_thr;
		logic signed [16:0] inst_thr;
		logic [9:0]         sus_frames;
		logic signed [12:0] cal;
	} slm_cfg_t;
endpackage

// File: design/slm_ifs.sv
// ----------------------------------------------------------------------------
// Sound level meter channel interfaces
// Valid/ready channels for slot words in and level results out.
// ----------------------------------------------------------------------------
interface slm_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] slot_word;
	logic is_left;
	logic frame_end;
	modport source (output valid, output slot_word, output is_left, output frame_end,
		input ready);
	modport sink (input valid, input slot_word, input is_left, input frame_end,
		output ready);
endinterface

interface slm_out_if;
	logic valid;
	logic ready;
	logic signed [16:0] level_db;
	logic instant_warning;
	logic sustained_warning;
	logic empty_frame;
	modport source (output valid, output level_db, output instant_warning,
		output sustained_warning, output empty_frame, input ready);
	modport sink (input valid, input level_db, input instant_warning,
		input sustained_warning, input empty_frame, output ready);
endinterface

// File: design/sound_level_meter_with_alarms_top.sv
// ----------------------------------------------------------------------------
// Sound level meter with alarms
// Frame RMS level in dB with instant and sustained threshold warnings.
// ----------------------------------------------------------------------------
// The block takes one I2S slot word per handshake and squares the left-channel
// samples (slot word shifted right by 8) into a running sum. The word that
// carries frame_end closes the frame and yields one result word: the level in
// 1/256 dB, 10*log10 of the mean square over 2^46 plus 123.0103 dB and the
// calibration register, with an instant and a sustained warning. A frame with
// no left samples reports the minimum level and sets empty_frame. An ordinary
// slot is captured and squared, then accumulated. A frame end then runs the
// shared log2 unit twice, once on the sum and once on the sample count, each
// pass being a bit-per-cycle normalize over SW bits (SW is 47 +
// log2(MAX_FRAME_SAMPLES)) plus squaring steps for 16 fraction bits, followed
// by the difference, scaling, offset and result-load steps. A silent or empty
// frame skips the log unit. A finished result waits in the output register
// while the next slot words are taken; only the following frame end waits
// for it.
// Configuration writes go straight into registers and are meant for idle time.
module sound_level_meter_with_alarms_top import slm_pkg::*; #(
	parameter int MAX_FRAME_SAMPLES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [16:0] cfg_wdata,
	slm_in_if.sink      in_ch,
	slm_out_if.source   out_ch
);
	slm_cfg_t    cfg_q;
	slm_cmd_t    cmd;
	slm_status_t status;

	// Register file; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sus_thr    <= 17'sd21760;
			cfg_q.inst_thr   <= 17'sd25600;
			cfg_q.sus_frames <= 10'd138;
			cfg_q.cal        <= '0;
		end else if (cfg_we && (cfg_index[7:2] == '0)) begin
			unique case (cfg_index[1:0])
				RegSusThr:    cfg_q.sus_thr    <= cfg_wdata;
				RegInstThr:   cfg_q.inst_thr   <= cfg_wdata;
				RegSusFrames: cfg_q.sus_frames <= cfg_wdata[9:0];
				RegCal:       cfg_q.cal        <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	slm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	slm_dp #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg               (cfg_q),
		.slot_word         (in_ch.slot_word),
		.is_left           (in_ch.is_left),
		.frame_end         (in_ch.frame_end),
		.out_ready         (out_ch.ready),
		.out_valid         (out_ch.valid),
		.level_db          (out_ch.level_db),
		.instant_warning   (out_ch.instant_warning),
		.sustained_warning (out_ch.sustained_warning),
		.empty_frame       (out_ch.empty_frame)
	);
endmodule

// File: design/slm_ctrl.sv
// ----------------------------------------------------------------------------
// Sound level meter controller
// Sequences accumulation and the frame-end log computation.
// ----------------------------------------------------------------------------
`include "sound_level_meter_with_alarms_top_defines.svh"
module slm_ctrl import slm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  slm_status_t status,
	output slm_cmd_t    cmd
);
	typedef enum logic [3:0] {
		IDLE, ACC, CHK, NORM, SQ, SWAP, DIFF, MUL, ADD, FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: if (in_valid) state_q <= ACC;
				ACC: state_q <= status.frame_end ? CHK : IDLE;
				CHK: begin
					if (status.count_zero) state_q <= FIN;
					else if (status.sum_zero) state_q <= ADD;
					else state_q <= NORM;
				end
				NORM: if (status.norm_msb) state_q <= SQ;
				SQ: if (status.k_zero) state_q <= status.sel ? DIFF : SWAP;
				SWAP: state_q <= NORM;
				DIFF: state_q <= MUL;
				MUL: state_q <= ADD;
				ADD: state_q <= FIN;
				FIN: if (status.out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd      = '0;
		cmd.take = (state_q == IDLE) && in_valid;
		cmd.acc  = (state_q == ACC);
		cmd.chk  = (state_q == CHK);
		cmd.norm = (state_q == NORM);
		cmd.sq   = (state_q == SQ);
		cmd.swap = (state_q == SWAP);
		cmd.diff = (state_q == DIFF);
		cmd.mul  = (state_q == MUL);
		cmd.add  = (state_q == ADD);
		cmd.fin  = (state_q == FIN) && status.out_free;
	end

	`SLM_ASSERT_NXT(a_take_to_acc, cmd.take, state_q == ACC)
	`SLM_ASSERT_NXT(a_empty_to_fin, (state_q == CHK) && status.count_zero, state_q == FIN)
	`SLM_ASSERT_NXT(a_fin_to_idle, cmd.fin, state_q == IDLE)
endmodule

// File: design/slm_dp.sv
// ----------------------------------------------------------------------------
// Sound level meter datapath
// Square accumulator, shared log2 unit, dB scaling and alarm logic.
// ----------------------------------------------------------------------------
module slm_dp import slm_pkg::*; #(
	parameter int MAX_FRAME_SAMPLES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  slm_cmd_t     cmd,
	output slm_status_t  status,
	input  slm_cfg_t     cfg,
	input  logic signed [31:0] slot_word,
	input  logic         is_left,
	input  logic         frame_end,
	input  logic         out_ready,
	output logic         out_valid,
	output logic signed [16:0] level_db,
	output logic         instant_warning,
	output logic         sustained_warning,
	output logic         empty_frame
);
	localparam int CW = $clog2(MAX_FRAME_SAMPLES) + 1;
	localparam int SW = 47 + $clog2(MAX_FRAME_SAMPLES);
	localparam int EW = $clog2(SW);
	localparam int LW = EW + 16;

	logic [46:0]           sq_s1;
	logic                  take_s1;
	logic                  fend_s1;
	logic [SW-1:0]         sum_q;
	logic [CW-1:0]         cnt_q;
	logic [SW-1:0]         norm_q;
	logic [EW-1:0]         e_q;
	logic [30:0]           m_q;
	logic [LW-1:0]         r_q;
	logic [LW-1:0]         lsum_q;
	logic [3:0]            k_q;
	logic                  sel_q;
	logic signed [LW:0]    d_q;
	logic signed [AccW-1:0] acc_q;
	logic                  empty_q;
	logic [9:0]            loud_q;
	logic                  out_valid_q;

	logic signed [23:0]    sample;
	logic signed [47:0]    sample_sq;
	logic [61:0]           m_sq;
	logic signed [AccW-33:0] q;
	logic signed [16:0]    level;
	logic [9:0]            loud_inc;

	assign sample    = slot_word[31:8];
	assign sample_sq = sample * sample;
	assign m_sq      = {31'd0, m_q} * {31'd0, m_q};
	assign q         = acc_q[AccW-1:32];
	assign loud_inc  = loud_q + 10'd1;

	always_comb begin
		if (empty_q || (q < (AccW-32)'(LevelMin))) level = 17'(LevelMin);
		else if (q > (AccW-32)'(LevelMax)) level = 17'(LevelMax);
		else level = q[16:0];
	end

	// Input capture and the registered square.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sq_s1   <= sample_sq[46:0];
			take_s1 <= is_left && (cnt_q < CW'(MAX_FRAME_SAMPLES));
			fend_s1 <= frame_end;
		end
	end

	// Log unit and scaling registers.
	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			norm_q  <= sum_q;
			e_q     <= EW'(SW - 1);
			sel_q   <= 1'b0;
			empty_q <= (cnt_q == '0);
			acc_q   <= AccW'(SilentAcc);
		end
		if (cmd.swap) begin
			lsum_q <= r_q;
			norm_q <= SW'(cnt_q);
			e_q    <= EW'(SW - 1);
			sel_q  <= 1'b1;
		end
		if (cmd.norm) begin
			if (norm_q[SW-1]) begin
				m_q <= norm_q[SW-1 -: 31];
				r_q <= {e_q, 16'd0};
				k_q <= 4'd15;
			end else begin
				norm_q <= norm_q << 1;
				e_q    <= e_q - EW'(1);
			end
		end
		if (cmd.sq) begin
			if (m_sq[61]) begin
				m_q <= m_sq[61:31];
				r_q <= r_q | (LW'(1) << k_q);
			end else begin
				m_q <= m_sq[60:30];
			end
			k_q <= k_q - 4'd1;
		end
		if (cmd.diff) d_q <= $signed({1'b0, lsum_q}) - $signed({1'b0, r_q})
			- (LW+1)'(46 * 65536);
		if (cmd.mul) acc_q <= AccW'(d_q * LogCoef);
		if (cmd.add) acc_q <= acc_q + AccW'(OffsetAcc)
			+ $signed({{(AccW-45){cfg.cal[12]}}, cfg.cal, 32'd0});
		if (cmd.fin) begin
			level_db          <= level;
			empty_frame       <= empty_q;
			instant_warning   <= !empty_q && (level >= cfg.inst_thr);
			sustained_warning <= !empty_q && (level >= cfg.sus_thr)
				&& (loud_inc >= cfg.sus_frames);
		end
	end

	// Frame state and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			loud_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc && take_s1) begin
				sum_q <= sum_q + SW'(sq_s1);
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.fin) begin
				sum_q <= '0;
				cnt_q <= '0;
				if (empty_q || (level < cfg.sus_thr) || (loud_inc >= cfg.sus_frames))
					loud_q <= '0;
				else
					loud_q <= loud_inc;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status.frame_end  = fend_s1;
	assign status.count_zero = (cnt_q == '0);
	assign status.sum_zero   = (sum_q == '0);
	assign status.norm_msb   = norm_q[SW-1];
	assign status.k_zero     = (k_q == 4'd0);
	assign status.sel        = sel_q;
	assign status.out_free   = !out_valid_q || out_ready;
endmodule
